### rtl/core/ccpr_pkg.sv
package ccpr_pkg;

  localparam int unsigned PacketBytes  = 5;
  localparam int unsigned EncodedBytes = 6;
  localparam int unsigned CrcCover     = 3;
  localparam logic [15:0] CrcPoly      = 16'h8408;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [7:0]  Delimiter    = 8'h00;
  localparam logic [7:0]  LongRunCode  = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ENC_LEN  = 3'd1,
    ST_OVERRUN  = 3'd2,
    ST_DEC_LEN  = 3'd3,
    ST_CRC      = 3'd4
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         packet_type;
    logic signed [15:0] reading;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic [7:0]  d;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

### rtl/core/ccpr_if.sv
interface ccpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ccpr_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         packet_type;
  logic signed [15:0] reading;

  modport source (output valid, output status, output packet_type, output reading,
                  input ready);
  modport sink (input valid, input status, input packet_type, input reading,
                output ready);
endinterface

### rtl/core/ccpr_frame_decoder.sv
module ccpr_frame_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output ccpr_pkg::result_t result
);
  import ccpr_pkg::*;

  logic [3:0]  enc_cnt_r,  enc_cnt_nxt;
  logic [7:0]  run_left_r, run_left_nxt;
  logic [7:0]  run_code_r, run_code_nxt;
  logic [2:0]  dec_cnt_r,  dec_cnt_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic        overrun_r,  overrun_nxt;
  logic [7:0]  dec_bytes_r [PacketBytes];

  logic        put_en;
  logic [7:0]  put_val;
  logic        store_en;
  logic        is_delim;
  logic [15:0] crc_got;

  assign is_delim = (rx_byte == Delimiter);
  assign store_en = step && !is_delim && put_en && (dec_cnt_r < 3'(PacketBytes));

  always_comb begin
    enc_cnt_nxt  = enc_cnt_r;
    run_left_nxt = run_left_r;
    run_code_nxt = run_code_r;
    dec_cnt_nxt  = dec_cnt_r;
    crc_nxt      = crc_r;
    overrun_nxt  = overrun_r;
    put_en       = 1'b0;
    put_val      = rx_byte;
    if (run_left_r == 8'd0) begin
      put_en  = (run_code_r != 8'd0) && (run_code_r != LongRunCode);
      put_val = 8'd0;
    end else begin
      put_en = 1'b1;
    end
    if (is_delim) begin
      enc_cnt_nxt  = '0;
      run_left_nxt = '0;
      run_code_nxt = '0;
      dec_cnt_nxt  = '0;
      crc_nxt      = CrcInit;
      overrun_nxt  = 1'b0;
    end else begin
      if (enc_cnt_r != 4'hF) begin
        enc_cnt_nxt = enc_cnt_r + 4'd1;
      end
      if (run_left_r == 8'd0) begin
        run_code_nxt = rx_byte;
        run_left_nxt = rx_byte - 8'd1;
      end else begin
        run_left_nxt = run_left_r - 8'd1;
      end
      if (put_en) begin
        if (dec_cnt_r < 3'(PacketBytes)) begin
          if (dec_cnt_r < 3'(CrcCover)) begin
            crc_nxt = crc_byte(crc_r, put_val);
          end
        end else begin
          overrun_nxt = 1'b1;
        end
        if (dec_cnt_r != 3'd7) begin
          dec_cnt_nxt = dec_cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_cnt_r  <= '0;
      run_left_r <= '0;
      run_code_r <= '0;
      dec_cnt_r  <= '0;
      crc_r      <= CrcInit;
      overrun_r  <= 1'b0;
    end else if (step) begin
      enc_cnt_r  <= enc_cnt_nxt;
      run_left_r <= run_left_nxt;
      run_code_r <= run_code_nxt;
      dec_cnt_r  <= dec_cnt_nxt;
      crc_r      <= crc_nxt;
      overrun_r  <= overrun_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      dec_bytes_r[dec_cnt_r] <= put_val;
    end
  end

  assign crc_got = {dec_bytes_r[3], dec_bytes_r[4]};

  always_comb begin
    result.status      = ST_OK;
    result.packet_type = '0;
    result.reading     = '0;
    if (enc_cnt_r != 4'(EncodedBytes)) begin
      result.status = ST_ENC_LEN;
    end else if ((run_left_r != 8'd0) || overrun_r) begin
      result.status = ST_OVERRUN;
    end else if (dec_cnt_r != 3'(PacketBytes)) begin
      result.status = ST_DEC_LEN;
    end else if (crc_got != ~crc_r) begin
      result.status = ST_CRC;
    end else begin
      result.packet_type = dec_bytes_r[0];
      result.reading     = {dec_bytes_r[1], dec_bytes_r[2]};
    end
  end

endmodule

### rtl/core/cobs_crc_packet_receiver.sv
// Receives a COBS-framed byte stream and checks each frame as a five-byte
// packet: a type byte, a signed big-endian 16-bit reading and a CRC-16/X-25.
// The in_ch channel carries one received byte per word; a zero byte is the
// frame delimiter. The out_ch channel carries one word per delimiter: a
// status, the packet type and the reading, the last two zero unless the
// status is ok.
// Each accepted byte is held in an input register and then folds into the
// frame state in a single pass. A delimiter goes from the input register
// into the output register, where its result waits for out_ch. One byte is
// accepted every cycle except while a stalled delimiter holds in_ch.ready low.
// The result sits in an output register. While it waits, non-zero bytes are
// still taken; only a delimiter in the input register waits until the result
// ahead of it has been taken, and in_ch.ready falls while it does.
// A synchronous reset empties both registers and returns the frame state to
// the start of a frame, so reception begins at the first code byte.
module cobs_crc_packet_receiver (
  input logic      clk,
  input logic      rst_n,
  ccpr_in_if.sink  in_ch,
  ccpr_out_if.source out_ch
);
  import ccpr_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    result;
  logic       out_free;
  logic       advance;
  logic       load_out;

  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = in_valid_r && ((in_byte_r != Delimiter) || out_free);
  assign load_out = advance && (in_byte_r == Delimiter);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (load_out) begin
      out_r <= result;
    end
  end

  ccpr_frame_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .result  (result)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.packet_type = out_r.packet_type;
  assign out_ch.reading     = out_r.reading;

  a_delim_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("delimiter did not produce a result");

  a_bad_frame_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |->
      ((out_r.packet_type == 8'd0) && (out_r.reading == 16'sd0)))
    else $error("bad frame carries payload");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |->
      (in_valid_r && (in_byte_r == Delimiter) && out_valid_r && !out_ch.ready))
    else $error("input stalled without a pending result");

endmodule
